// File: hdl/pnoise_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_pkg
// Shared constants, types and tables for the 3D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pnoise_pkg;

    localparam int CELL_BITS   = 8;
    localparam int PERM_SIZE   = 256;
    localparam int GIDX_BITS   = 4;
    localparam int GRAD_COUNT  = 12;
    localparam int COORD_W     = 32;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_W       = 16;
    localparam int CORNERS     = 8;

    // h mod 12 is taken as h - 12 * floor(h * 171 / 2048), exact for 8-bit h.
    localparam logic [15:0] MOD12_RECIP = 16'd171;
    localparam int          MOD12_SHIFT = 11;

    typedef logic [CELL_BITS-1:0] t_cell;
    typedef logic [GIDX_BITS-1:0] t_gidx;

    localparam t_cell PERM_ROM [PERM_SIZE] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,
        8'd53,8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
        8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,
        8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,
        8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,
        8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,
        8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,
        8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,
        8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,
        8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,
        8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,
        8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
        8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,
        8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,
        8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,
        8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,
        8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
        8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,
        8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,
        8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,
        8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    // Edge gradients; the four codes past the twelfth never occur.
    localparam logic signed [1:0] GRAD_X [16] = '{
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1,
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] GRAD_Y [16] = '{
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] GRAD_Z [16] = '{
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1,
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};

    function automatic t_gidx grad_index(input t_cell h);
        logic [15:0] prod;
        logic [7:0]  quo;
        logic [7:0]  rem;
        prod = 16'(h) * MOD12_RECIP;
        quo  = 8'(prod >> MOD12_SHIFT);
        rem  = h - 8'(quo * 8'(GRAD_COUNT));
        return rem[GIDX_BITS-1:0];
    endfunction

endpackage

// File: hdl/perlin_noise_3d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_top
// Classic 3D gradient noise through a 12-stage pipeline, one point per cycle unless the output stalls.
//
//   Channel   Direction  Payload
//   s_axis    in         x_coord[31:0], y_coord[63:32], z_coord[95:64]
//   m_axis    out        noise_value[15:0]
//
// One point is accepted per cycle while the output side does not stall; each
// result then moves through the stages below in order to the output register.
// Stages: input register, three hash/fade stages, dot products, three
// two-stage blends, output rounding and saturation register.
// Each stage advances when it is empty or the stage after it advances, so a
// stall fills bubbles first and never drops or repeats a point.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module perlin_noise_3d_top #(
    parameter int FRAC_BITS     = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // x_coord, y_coord, z_coord from bit 0 up
    input  logic [pnoise_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // noise_value
    output logic [pnoise_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import pnoise_pkg::*;

    localparam int FB     = FRAC_BITS;
    localparam int W      = FB + 3;
    localparam int STAGES = 12;
    localparam int UP     = (OUT_FRAC_BITS >= FB) ? OUT_FRAC_BITS - FB : 0;
    localparam int DN     = (OUT_FRAC_BITS < FB) ? FB - OUT_FRAC_BITS : 1;
    localparam int CW     = W + UP + 1;
    localparam logic signed [W-1:0]  ONE_FIX = W'(1) << FB;
    localparam logic signed [CW-1:0] RND     = CW'(1) << (DN - 1);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    t_cell         r_xi0, r_yi0, r_zi0;
    logic [FB-1:0] r_f0 [3];
    logic [FB-1:0] r_f1 [3];
    logic [FB-1:0] r_f2 [3];
    logic [FB-1:0] r_f3 [3];
    logic signed [W-1:0] r_dot [CORNERS];
    logic [FB:0]   r_u4, r_v4, r_w4, r_v5, r_v6, r_w5, r_w6, r_w7, r_w8;
    logic [OUT_W-1:0] r_out;

    t_gidx               w_gidx [CORNERS];
    logic [FB:0]         w_fade [3];
    logic signed [W-1:0] w_xa [4];
    logic signed [W-1:0] w_xb [4];
    logic signed [W-1:0] w_ax [4];
    logic signed [W-1:0] w_ya [2];
    logic signed [W-1:0] w_yb [2];
    logic signed [W-1:0] w_ay [2];
    logic signed [W-1:0] w_za [1];
    logic signed [W-1:0] w_zb [1];
    logic signed [W-1:0] w_az [1];
    logic signed [CW-1:0] w_conv;
    logic [OUT_W-1:0]    n_out;
    logic signed [W-1:0] w_dot [CORNERS];

    function automatic logic signed [W-1:0] gterm(input logic signed [1:0] g,
                                                  input logic signed [W-1:0] d);
        logic signed [W-1:0] res;
        res = '0;
        if (g > 0) begin
            res = d;
        end else if (g < 0) begin
            res = -d;
        end
        return res;
    endfunction

    // Stage enables ripple back from the output register.
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_xi0   <= i_s_axis_tdata[FB +: CELL_BITS];
            r_yi0   <= i_s_axis_tdata[COORD_W + FB +: CELL_BITS];
            r_zi0   <= i_s_axis_tdata[2*COORD_W + FB +: CELL_BITS];
            r_f0[0] <= i_s_axis_tdata[0 +: FB];
            r_f0[1] <= i_s_axis_tdata[COORD_W +: FB];
            r_f0[2] <= i_s_axis_tdata[2*COORD_W +: FB];
        end
        if (w_en[1]) r_f1 <= r_f0;
        if (w_en[2]) r_f2 <= r_f1;
        if (w_en[3]) r_f3 <= r_f2;
    end

    pnoise_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (w_en[3:1]),
        .i_xi   (r_xi0),
        .i_yi   (r_yi0),
        .i_zi   (r_zi0),
        .o_gidx (w_gidx)
    );

    pnoise_fade #(.FB(FB)) u_fade (
        .i_clk  (i_clk),
        .i_en   (w_en[3:1]),
        .i_t    (r_f0),
        .o_fade (w_fade)
    );

    // Corner c carries its x, y and z offsets in bits 2, 1 and 0.
    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            logic signed [W-1:0] dx, dy, dz;
            dx = W'(r_f3[0]) - (((c >> 2) & 1) != 0 ? ONE_FIX : W'(0));
            dy = W'(r_f3[1]) - (((c >> 1) & 1) != 0 ? ONE_FIX : W'(0));
            dz = W'(r_f3[2]) - ((c & 1) != 0 ? ONE_FIX : W'(0));
            w_dot[c] = gterm(GRAD_X[w_gidx[c]], dx) + gterm(GRAD_Y[w_gidx[c]], dy)
                     + gterm(GRAD_Z[w_gidx[c]], dz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_dot <= w_dot;
            r_u4  <= w_fade[0];
            r_v4  <= w_fade[1];
            r_w4  <= w_fade[2];
        end
        if (w_en[5]) begin
            r_v5 <= r_v4;
            r_w5 <= r_w4;
        end
        if (w_en[6]) begin
            r_v6 <= r_v5;
            r_w6 <= r_w5;
        end
        if (w_en[7]) r_w7 <= r_w6;
        if (w_en[8]) r_w8 <= r_w7;
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_xa[j] = r_dot[j];
            w_xb[j] = r_dot[j+4];
        end
        for (int j = 0; j < 2; j++) begin
            w_ya[j] = w_ax[j];
            w_yb[j] = w_ax[j+2];
        end
        w_za[0] = w_ay[0];
        w_zb[0] = w_ay[1];
    end

    pnoise_lerp #(.W(W), .FB(FB), .LANES(4)) u_lerp_x (
        .i_clk (i_clk),
        .i_en  (w_en[6:5]),
        .i_a   (w_xa),
        .i_b   (w_xb),
        .i_s   (r_u4),
        .o_r   (w_ax)
    );

    pnoise_lerp #(.W(W), .FB(FB), .LANES(2)) u_lerp_y (
        .i_clk (i_clk),
        .i_en  (w_en[8:7]),
        .i_a   (w_ya),
        .i_b   (w_yb),
        .i_s   (r_v6),
        .o_r   (w_ay)
    );

    pnoise_lerp #(.W(W), .FB(FB), .LANES(1)) u_lerp_z (
        .i_clk (i_clk),
        .i_en  (w_en[10:9]),
        .i_a   (w_za),
        .i_b   (w_zb),
        .i_s   (r_w8),
        .o_r   (w_az)
    );

    if (OUT_FRAC_BITS >= FRAC_BITS) begin : g_scale_up
        assign w_conv = CW'(w_az[0]) <<< UP;
    end else begin : g_round
        assign w_conv = (CW'(w_az[0]) + RND) >>> DN;
    end

    always_comb begin
        if (w_conv > 32767) begin
            n_out = 16'h7fff;
        end else if (w_conv < -32768) begin
            n_out = 16'h8000;
        end else begin
            n_out = OUT_W'(w_conv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/pnoise_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_hash
// Three-stage corner hash: z, then y, then x permutation lookups per corner.
// ----------------------------------------------------------------------------
module pnoise_hash (
    input  logic                 i_clk,
    input  logic [2:0]           i_en,
    input  pnoise_pkg::t_cell    i_xi,
    input  pnoise_pkg::t_cell    i_yi,
    input  pnoise_pkg::t_cell    i_zi,
    output pnoise_pkg::t_gidx    o_gidx [8]
);
    import pnoise_pkg::*;

    t_cell r_pz [2];
    t_cell r_xi1, r_yi1;
    t_cell r_py [4];
    t_cell r_xi2;
    t_gidx r_gidx [CORNERS];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pz[0] <= PERM_ROM[i_zi];
            r_pz[1] <= PERM_ROM[t_cell'(i_zi + 8'd1)];
            r_xi1   <= i_xi;
            r_yi1   <= i_yi;
        end
        if (i_en[1]) begin
            for (int c = 0; c < 4; c++) begin
                r_py[c] <= PERM_ROM[t_cell'(r_yi1 + t_cell'(c >> 1) + r_pz[c & 1])];
            end
            r_xi2 <= r_xi1;
        end
        if (i_en[2]) begin
            for (int c = 0; c < CORNERS; c++) begin
                r_gidx[c] <= grad_index(
                    PERM_ROM[t_cell'(r_xi2 + t_cell'(c >> 2) + r_py[c & 3])]);
            end
        end
    end

    assign o_gidx = r_gidx;

endmodule

// File: hdl/pnoise_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_fade
// Three-stage Hermite fade 3t^2 - 2t^3 for the three fractions.
// ----------------------------------------------------------------------------
module pnoise_fade #(
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic [2:0]    i_en,
    input  logic [FB-1:0] i_t    [3],
    output logic [FB:0]   o_fade [3]
);
    import pnoise_pkg::*;

    logic [FB-1:0] r_t1  [3];
    logic [FB-1:0] r_t2a [3];
    logic [FB-1:0] r_t2b [3];
    logic [FB-1:0] r_t3  [3];
    logic [FB:0]   r_fade [3];

    logic [2*FB-1:0] w_sq  [3];
    logic [2*FB-1:0] w_cu  [3];
    logic [FB+2:0]   w_sum [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sq[l]  = (2*FB)'(i_t[l]) * (2*FB)'(i_t[l]);
            w_cu[l]  = (2*FB)'(r_t2a[l]) * (2*FB)'(r_t1[l]);
            w_sum[l] = (FB+3)'(r_t2b[l]) * (FB+3)'(3) - (FB+3)'(r_t3[l]) * (FB+3)'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (i_en[0]) begin
                r_t1[l]  <= i_t[l];
                r_t2a[l] <= w_sq[l][2*FB-1:FB];
            end
            if (i_en[1]) begin
                r_t2b[l] <= r_t2a[l];
                r_t3[l]  <= w_cu[l][2*FB-1:FB];
            end
            if (i_en[2]) begin
                r_fade[l] <= w_sum[l][FB:0];
            end
        end
    end

    assign o_fade = r_fade;

endmodule

// File: hdl/pnoise_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_lerp
// Two-stage linear blend a + floor((b - a) * s / one) over several lanes.
// ----------------------------------------------------------------------------
module pnoise_lerp #(
    parameter int W     = 19,
    parameter int FB    = 16,
    parameter int LANES = 4
) (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  logic signed [W-1:0] i_a [LANES],
    input  logic signed [W-1:0] i_b [LANES],
    input  logic [FB:0]         i_s,
    output logic signed [W-1:0] o_r [LANES]
);
    import pnoise_pkg::*;

    localparam int PW = W + FB + 3;

    logic signed [W-1:0]  r_a [LANES];
    logic signed [PW-1:0] r_p [LANES];
    logic signed [W-1:0]  r_r [LANES];

    logic signed [PW-1:0] w_d [LANES];
    logic signed [PW-1:0] w_s;

    always_comb begin
        w_s = PW'(signed'({1'b0, i_s}));
        for (int l = 0; l < LANES; l++) begin
            w_d[l] = PW'(i_b[l]) - PW'(i_a[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_en[0]) begin
                r_a[l] <= i_a[l];
                r_p[l] <= w_d[l] * w_s;
            end
            if (i_en[1]) begin
                // The arithmetic shift floors toward minus infinity.
                r_r[l] <= r_a[l] + W'(r_p[l] >>> FB);
            end
        end
    end

    assign o_r = r_r;

endmodule

// File: hdl/pnoise_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnoise_chk
// Port-level checks for the noise pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pnoise_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [pnoise_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [pnoise_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import pnoise_pkg::*;

    // A waiting result holds its data until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // When the output register can move, every stage can move.
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input blocked with a free pipeline");

endmodule

bind perlin_noise_3d_top pnoise_chk u_pnoise_chk (.*);
